### rtl/rsc_pkg.sv
// Shared types, codes and helpers for the three-rotor stream cipher.
// No dependencies; imported by every rtl module of the block.
package rsc_pkg;

   // Input word field widths
   localparam int MODE_W  = 2;
   localparam int RSEL_W  = 2;
   localparam int WIDX_W  = 5;
   localparam int WVAL_W  = 5;
   localparam int BYTE_W  = 8;
   localparam int START_W = 5;

   // Request word: mode, rotor_select, wiring_index, wiring_value, byte_in
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   // Mode codes
   localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RESTART = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CIPHER  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_IGNORE  = 2'd3;

   // Start position register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_THIRD  = 2'd2;
   localparam int START_REGS = 3;

   localparam logic [BYTE_W-1:0] LETTER_BASE = 8'h41;

   // Control carried with each word down the rotor chain
   typedef struct packed {
      logic [RSEL_W-1:0] rotor_select;
      logic [WIDX_W-1:0] wiring_index;
      logic [WVAL_W-1:0] wiring_value;
      logic [BYTE_W-1:0] byte_in;
      logic              wr;
      logic              cipher;
      logic              letter;
   } item_ctl_type;

   // 5-bit value modulo a small modulus by restoring compare-subtract
   function automatic logic [4:0] mod_reduce(input logic [4:0] val,
                                             input logic [5:0] modulus);
      logic [10:0] rem;
      logic [10:0] sub;
      rem = {6'd0, val};
      for (int j = 4; j >= 0; j--) begin
         sub = {5'd0, modulus} << j;
         if (rem >= sub) begin
            rem = rem - sub;
         end
      end
      return rem[4:0];
   endfunction

endpackage

### rtl/rsc_stepper.sv
// Rotor position odometer and start position registers.
// Depends on rsc_pkg; feeds the position snapshot to the first rotor cell.
module rsc_stepper import rsc_pkg::*; #(
   parameter int ALPHABET_SIZE = 26,
   parameter int ROTOR_COUNT   = 3,
   parameter int LW            = $clog2(ALPHABET_SIZE)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [START_W-1:0]        csr_wdata,
   input  logic                      accept,
   input  logic                      restart,
   input  logic                      step,
   output logic [ROTOR_COUNT*LW-1:0] pos
);

   logic [LW-1:0] start_ff [START_REGS];
   logic [LW-1:0] pos_ff   [ROTOR_COUNT];
   logic [LW-1:0] pos_in   [ROTOR_COUNT];
   logic [LW-1:0] csr_mod;
   logic          carry    [ROTOR_COUNT+1];

   assign csr_mod = LW'(mod_reduce(csr_wdata, 6'(ALPHABET_SIZE)));

   // Start registers, stored already reduced
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < START_REGS; i++) begin
            start_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_FIRST:  start_ff[0] <= csr_mod;
            CSR_START_SECOND: start_ff[1] <= csr_mod;
            CSR_START_THIRD:  start_ff[2] <= csr_mod;
            default: ;
         endcase
      end
   end

   // Next positions: restart load or odometer carry chain
   always_comb begin
      carry[0] = step;
      for (int i = 0; i < ROTOR_COUNT; i++) begin
         carry[i+1] = carry[i] && (int'(pos_ff[i]) == ALPHABET_SIZE - 1);
         if (restart) begin
            pos_in[i] = (i < START_REGS) ? start_ff[i] : '0;
         end else if (carry[i]) begin
            pos_in[i] = (int'(pos_ff[i]) == ALPHABET_SIZE - 1) ? '0 : pos_ff[i] + 1'b1;
         end else begin
            pos_in[i] = pos_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROTOR_COUNT; i++) begin
            pos_ff[i] <= '0;
         end
      end else if (accept) begin
         for (int i = 0; i < ROTOR_COUNT; i++) begin
            pos_ff[i] <= pos_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < ROTOR_COUNT; i++) begin
         pos[i*LW +: LW] = pos_ff[i];
      end
   end

   // First rotor always moves on a ciphered letter
   a_first_steps: assert property (@(posedge clock) disable iff (reset)
      accept && step && !restart |=> pos_ff[0] != $past(pos_ff[0]))
      else $error("first rotor did not step");

   // Positions only move on an accepted word
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> pos_ff[0] == $past(pos_ff[0]))
      else $error("position moved without a word");

   // Position stays inside the alphabet
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      int'(pos_ff[0]) < ALPHABET_SIZE)
      else $error("position out of range");

endmodule

### rtl/rsc_cell.sv
// One rotor cell: its wiring table, offset by position and lookup, one stage.
// Depends on rsc_pkg; chained ROTOR_COUNT times by the top level.
module rsc_cell import rsc_pkg::*; #(
   parameter int ALPHABET_SIZE = 26,
   parameter int ROTOR_COUNT   = 3,
   parameter int CELL_IDX      = 0,
   parameter int LW            = $clog2(ALPHABET_SIZE)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  item_ctl_type              in_ctl,
   input  logic [LW-1:0]             in_sig,
   input  logic [ROTOR_COUNT*LW-1:0] in_pos,
   output logic                      out_valid,
   input  logic                      out_ready,
   output item_ctl_type              out_ctl,
   output logic [LW-1:0]             out_sig,
   output logic [ROTOR_COUNT*LW-1:0] out_pos
);

   logic [LW-1:0]             wiring_ff [ALPHABET_SIZE];
   logic                      valid_ff;
   item_ctl_type              ctl_ff;
   logic [LW-1:0]             sig_ff;
   logic [ROTOR_COUNT*LW-1:0] pos_ff;

   logic [LW-1:0] pos_here;
   logic [LW:0]   sum;
   logic [LW:0]   contact;
   logic [LW-1:0] mapped;
   logic [LW-1:0] sig_in;
   logic          accept;
   logic          wr_hit;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   // Offset by this rotor's position, wrap once, look up the wiring
   assign pos_here = in_pos[CELL_IDX*LW +: LW];
   assign sum      = {1'b0, in_sig} + {1'b0, pos_here};
   assign contact  = (sum >= (LW+1)'(ALPHABET_SIZE)) ? sum - (LW+1)'(ALPHABET_SIZE) : sum;
   assign mapped   = wiring_ff[contact[LW-1:0]];
   assign sig_in   = (in_ctl.cipher && in_ctl.letter) ? mapped : in_sig;

   // Wiring write for this rotor, in stream order with the letters
   assign wr_hit = accept && in_ctl.wr
                   && (int'(in_ctl.rotor_select) == CELL_IDX)
                   && (int'(in_ctl.wiring_index) < ALPHABET_SIZE);

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         wiring_ff[in_ctl.wiring_index[LW-1:0]] <=
            LW'(mod_reduce(in_ctl.wiring_value, 6'(ALPHABET_SIZE)));
      end
   end

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctl_ff <= in_ctl;
         sig_ff <= sig_in;
         pos_ff <= in_pos;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_sig   = sig_ff;
   assign out_pos   = pos_ff;

   // An accepted word shows up in the stage register
   a_enter: assert property (@(posedge clock) disable iff (reset)
      accept |=> valid_ff)
      else $error("accepted word lost in cell");

   // A stalled word is not dropped
   a_stall: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(sig_ff))
      else $error("stalled word changed in cell");

   // Control of a stalled word holds too
   a_stall_ctl: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> $stable(ctl_ff))
      else $error("stalled control changed in cell");

endmodule

### rtl/three_rotor_stream_cipher.sv
// Three-rotor stream cipher top level: request decode, odometer, chain of rotor cells.
// Depends on rsc_pkg, rsc_stepper and rsc_cell.
// One request word is taken per cycle unless rsp_tready holds back a result word; each
// word runs down a chain of ROTOR_COUNT cells (3 by default), one registered cell per
// rotor, and results leave at one per cycle while rsp_tready is high. Every cell holds
// its own wiring table in flops and a wiring write travels down the chain like a letter,
// so writes and letters take effect in stream order. Positions are snapshotted at the
// input and carried along with each word.
// Modes 0, 1 and 3 give no result word; mode 2 always gives one.
module three_rotor_stream_cipher import rsc_pkg::*; #(
   parameter int ALPHABET_SIZE = 26,
   parameter int ROTOR_COUNT   = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: mode[1:0], rotor_select[3:2], wiring_index[8:4],
   //            wiring_value[13:9], byte_in[21:14], zero[23:22]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: byte_out[7:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [START_W-1:0]    csr_wdata
);

   localparam int LW = $clog2(ALPHABET_SIZE);

   logic [MODE_W-1:0]         req_mode;
   logic [BYTE_W-1:0]         req_byte;
   logic [BYTE_W-1:0]         req_off;
   logic                      req_accept;
   logic                      req_letter;

   logic                      valid_c [ROTOR_COUNT+1];
   logic                      ready_c [ROTOR_COUNT+1];
   item_ctl_type              ctl_c   [ROTOR_COUNT+1];
   logic [LW-1:0]             sig_c   [ROTOR_COUNT+1];
   logic [ROTOR_COUNT*LW-1:0] pos_c   [ROTOR_COUNT+1];

   // Request decode
   assign req_mode   = req_tdata[1:0];
   assign req_byte   = req_tdata[21:14];
   assign req_off    = req_byte - LETTER_BASE;
   assign req_letter = (req_byte >= LETTER_BASE)
                       && (int'(req_byte) < int'(LETTER_BASE) + ALPHABET_SIZE);
   assign req_accept = req_tvalid && req_tready;
   assign req_tready = ready_c[0];

   always_comb begin
      ctl_c[0].rotor_select = req_tdata[3:2];
      ctl_c[0].wiring_index = req_tdata[8:4];
      ctl_c[0].wiring_value = req_tdata[13:9];
      ctl_c[0].byte_in      = req_byte;
      ctl_c[0].letter       = req_letter;
      ctl_c[0].wr           = 1'b0;
      ctl_c[0].cipher       = 1'b0;
      case (req_mode)
         MODE_WRITE:   ctl_c[0].wr = 1'b1;
         MODE_CIPHER:  ctl_c[0].cipher = 1'b1;
         MODE_RESTART: ;
         MODE_IGNORE:  ;
         default: ;
      endcase
   end

   assign valid_c[0] = req_tvalid;
   assign sig_c[0]   = req_off[LW-1:0];

   // Position odometer
   rsc_stepper #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .ROTOR_COUNT   (ROTOR_COUNT),
      .LW            (LW)
   ) u_stepper (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (req_accept),
      .restart   (req_accept && (req_mode == MODE_RESTART)),
      .step      (req_accept && (req_mode == MODE_CIPHER) && req_letter),
      .pos       (pos_c[0])
   );

   // Chain of rotor cells
   for (genvar g = 0; g < ROTOR_COUNT; g++) begin : g_cell
      rsc_cell #(
         .ALPHABET_SIZE (ALPHABET_SIZE),
         .ROTOR_COUNT   (ROTOR_COUNT),
         .CELL_IDX      (g),
         .LW            (LW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_c[g]),
         .in_ready  (ready_c[g]),
         .in_ctl    (ctl_c[g]),
         .in_sig    (sig_c[g]),
         .in_pos    (pos_c[g]),
         .out_valid (valid_c[g+1]),
         .out_ready (ready_c[g+1]),
         .out_ctl   (ctl_c[g+1]),
         .out_sig   (sig_c[g+1]),
         .out_pos   (pos_c[g+1])
      );
   end

   // Result word; non-cipher words drain without a handshake
   assign rsp_tvalid            = valid_c[ROTOR_COUNT] && ctl_c[ROTOR_COUNT].cipher;
   assign ready_c[ROTOR_COUNT]  = rsp_tready || !ctl_c[ROTOR_COUNT].cipher;
   assign rsp_tdata = ctl_c[ROTOR_COUNT].letter
                      ? LETTER_BASE + BYTE_W'(sig_c[ROTOR_COUNT])
                      : ctl_c[ROTOR_COUNT].byte_in;

endmodule
